// File: hdl/ibase_pkg.sv
// ----------------------------------------------------------------------------
// ibase_pkg
// Shared constants, types and helper functions of the integer to base text
// converter.
// ----------------------------------------------------------------------------
package ibase_pkg;

    localparam int C_VALUE_BITS = 32;
    localparam int C_BASE_BITS  = 6;
    localparam int C_CHAR_BITS  = 7;

    localparam logic [C_BASE_BITS-1:0] C_BASE_RESET    = 6'd10;
    localparam logic [C_BASE_BITS-1:0] C_RADIX_MIN     = 6'd2;
    localparam logic [C_BASE_BITS-1:0] C_RADIX_MAX     = 6'd36;
    localparam logic [C_BASE_BITS-1:0] C_DECIMAL_LIMIT = 6'd10;

    localparam logic [C_CHAR_BITS-1:0] C_ASCII_ZERO    = 7'd48;
    localparam logic [C_CHAR_BITS-1:0] C_ASCII_UPPER_A = 7'd65;
    localparam logic [C_CHAR_BITS-1:0] C_ASCII_MINUS   = 7'd45;

    typedef logic [C_BASE_BITS-1:0] t_digit;
    typedef logic [C_CHAR_BITS-1:0] t_char;

    typedef struct packed {
        logic clear;
        logic feed;
        logic shift;
    } t_array_ctl;

    function automatic t_digit f_clamp_radix(input t_digit base);
        t_digit radix;
        radix = base;
        if (base < C_RADIX_MIN) begin
            radix = C_RADIX_MIN;
        end else if (base > C_RADIX_MAX) begin
            radix = C_RADIX_MAX;
        end
        return radix;
    endfunction

    function automatic t_char f_digit_to_ascii(input t_digit d);
        t_char code;
        if (d < C_DECIMAL_LIMIT) begin
            code = {1'b0, d} + C_ASCII_ZERO;
        end else begin
            code = {1'b0, d} - {1'b0, C_DECIMAL_LIMIT} + C_ASCII_UPPER_A;
        end
        return code;
    endfunction

endpackage

// File: hdl/integer_to_base_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_base_ascii
// Converts a signed integer to ASCII text in a programmable radix, one
// character per output transaction, most significant character first.
// ----------------------------------------------------------------------------
// One input transaction is taken at a time. Its magnitude is fed one bit per
// cycle into a row of VALUE_BITS digit cells, and the bits ripple up the row
// one cell per cycle. The row is then shifted toward its top cell to drop
// leading zero digits, keeping at least one, and each digit is sent out as
// the output takes it, with a '-' first for negative input. The radix register
// is sampled during conversion and must be written only while the block is
// idle; values below 2 act as 2 and values above 36 act as 36.
// ----------------------------------------------------------------------------
module integer_to_base_ascii #(
    parameter int VALUE_BITS = ibase_pkg::C_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_number_base_we,
    input  ibase_pkg::t_digit     i_number_base,
    output logic                  o_valid,
    input  logic                  i_stall,
    output ibase_pkg::t_char      o_character,
    output logic                  o_last_char
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FEED  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_SKIP  = 3'd3;
    localparam logic [2:0] S_SIGN  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]            r_state, n_state;
    ibase_pkg::t_digit     r_base;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_digits, n_digits;
    logic                  r_ovalid, n_ovalid;
    ibase_pkg::t_char      r_char, n_char;
    logic                  r_last, n_last;

    logic                  w_accept;
    logic                  w_slot;
    logic                  w_load;
    logic                  w_skip;
    logic                  w_busy;
    ibase_pkg::t_digit     w_radix;
    ibase_pkg::t_digit     w_top;
    ibase_pkg::t_array_ctl w_ctl;

    assign o_stall  = r_state != S_IDLE;
    assign w_accept = i_valid & ~o_stall;
    assign w_slot   = ~r_ovalid | ~i_stall;
    assign w_radix  = ibase_pkg::f_clamp_radix(r_base);
    assign w_skip   = (w_top == '0) && (r_digits > CNT_W'(1));

    assign w_ctl.clear = w_accept;
    assign w_ctl.feed  = r_state == S_FEED;
    assign w_ctl.shift = ((r_state == S_SKIP) && w_skip) ||
                         ((r_state == S_EMIT) && w_slot);

    ibase_array #(
        .CELLS (VALUE_BITS)
    ) u_array (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_bit       (r_mag[VALUE_BITS-1]),
        .i_radix     (w_radix),
        .o_top_digit (w_top),
        .o_busy      (w_busy)
    );

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        n_digits = r_digits;
        n_char   = r_char;
        n_last   = r_last;
        w_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_neg   = i_value[VALUE_BITS-1];
                    n_mag   = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
                    n_cnt   = '0;
                    n_state = S_FEED;
                end
            end
            S_FEED: begin
                n_mag = r_mag << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_digits = CNT_W'(VALUE_BITS);
                if (!w_busy) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (w_skip) begin
                    n_digits = r_digits - 1'b1;
                end else begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (w_slot) begin
                    w_load  = 1'b1;
                    n_char  = ibase_pkg::C_ASCII_MINUS;
                    n_last  = 1'b0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot) begin
                    w_load   = 1'b1;
                    n_char   = ibase_pkg::f_digit_to_ascii(w_top);
                    n_last   = r_digits == CNT_W'(1);
                    n_digits = r_digits - 1'b1;
                    if (r_digits == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ovalid = w_load | (r_ovalid & i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= ibase_pkg::C_BASE_RESET;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_digits <= '0;
            r_neg    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_digits <= n_digits;
            r_neg    <= n_neg;
            if (i_number_base_we) begin
                r_base <= i_number_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last_char = r_last;

endmodule

// File: hdl/ibase_cell.sv
// ----------------------------------------------------------------------------
// ibase_cell
// One digit cell: doubles its digit in the current radix and adds the
// incoming bit, passing the overflow on; also shifts digits during readout.
// ----------------------------------------------------------------------------
module ibase_cell (
    input  logic                 i_clk,
    input  ibase_pkg::t_array_ctl i_ctl,
    input  logic                 i_tok,
    input  logic                 i_carry,
    input  ibase_pkg::t_digit    i_radix,
    input  ibase_pkg::t_digit    i_shift_digit,
    output ibase_pkg::t_digit    o_digit,
    output logic                 o_carry
);

    ibase_pkg::t_digit r_digit;
    ibase_pkg::t_digit n_digit;
    logic [ibase_pkg::C_BASE_BITS:0] w_sum;
    logic [ibase_pkg::C_BASE_BITS:0] w_diff;
    logic                            w_ge;

    assign w_sum  = {r_digit, i_carry};
    assign w_ge   = w_sum >= {1'b0, i_radix};
    assign w_diff = w_sum - {1'b0, i_radix};
    assign n_digit = w_ge ? w_diff[ibase_pkg::C_BASE_BITS-1:0]
                          : w_sum[ibase_pkg::C_BASE_BITS-1:0];
    assign o_carry = i_tok & w_ge;
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= '0;
        end else if (i_ctl.shift) begin
            r_digit <= i_shift_digit;
        end else if (i_tok) begin
            r_digit <= n_digit;
        end
    end

endmodule

// File: hdl/ibase_array.sv
// ----------------------------------------------------------------------------
// ibase_array
// Row of digit cells. Magnitude bits enter cell zero most significant first
// and ripple upward one cell per cycle as a wavefront; for readout the row
// shifts toward the top cell.
// ----------------------------------------------------------------------------
module ibase_array #(
    parameter int CELLS = ibase_pkg::C_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ibase_pkg::t_array_ctl i_ctl,
    input  logic                  i_bit,
    input  ibase_pkg::t_digit     i_radix,
    output ibase_pkg::t_digit     o_top_digit,
    output logic                  o_busy
);

    logic [CELLS-1:0]  w_tok;
    logic [CELLS-1:0]  w_cin;
    logic [CELLS-1:0]  w_cout;
    ibase_pkg::t_digit w_digit [CELLS];
    ibase_pkg::t_digit w_shift [CELLS];
    logic [CELLS-1:1]  r_tok;
    logic [CELLS-1:1]  r_carry;

    assign w_tok[0] = i_ctl.feed;
    assign w_cin[0] = i_bit;
    assign w_tok[CELLS-1:1] = r_tok;
    assign w_cin[CELLS-1:1] = r_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_ctl.clear) begin
            r_tok <= '0;
        end else begin
            r_tok <= w_tok[CELLS-2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= w_cout[CELLS-2:0];
    end

    genvar j;
    generate
        for (j = 0; j < CELLS; j++) begin : g_cell
            if (j == 0) begin : g_first
                assign w_shift[j] = '0;
            end else begin : g_rest
                assign w_shift[j] = w_digit[j-1];
            end
            ibase_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (i_ctl),
                .i_tok         (w_tok[j]),
                .i_carry       (w_cin[j]),
                .i_radix       (i_radix),
                .i_shift_digit (w_shift[j]),
                .o_digit       (w_digit[j]),
                .o_carry       (w_cout[j])
            );
        end
    endgenerate

    assign o_top_digit = w_digit[CELLS-1];
    assign o_busy      = |r_tok;

endmodule

// File: verif/integer_to_base_ascii_tb.sv
// ----------------------------------------------------------------------------
// integer_to_base_ascii_tb
// Self-checking testbench for the integer to base text converter. Each value
// sent in is also converted by a small model inside the bench, and every
// character that comes out is compared with the oldest expected one. Both
// sides idle at random, the output is held off for a long stretch once, and
// the radix register is written between phases while the block is idle.
// ----------------------------------------------------------------------------
module integer_to_base_ascii_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          VALUE_BITS = ibase_pkg::C_VALUE_BITS;
    localparam int unsigned RUN_LIMIT  = 500000;
    localparam int          DRAIN_GAP  = 4;
    localparam int          END_GAP    = 120;
    localparam int          HOLD_LEN   = 600;
    localparam int          MAX_REPORT = 10;
    localparam int          IDLE_PCT   = 30;

    typedef struct packed {
        ibase_pkg::t_char character;
        logic             last_char;
    } t_char_rec;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_valid          = 1'b0;
    logic                  o_stall;
    logic [VALUE_BITS-1:0] i_value          = '0;
    logic                  i_number_base_we = 1'b0;
    ibase_pkg::t_digit     i_number_base    = ibase_pkg::C_BASE_RESET;
    logic                  o_valid;
    logic                  i_stall          = 1'b0;
    ibase_pkg::t_char      o_character;
    logic                  o_last_char;

    t_char_rec         expected_chars[$];
    ibase_pkg::t_digit base_setting = ibase_pkg::C_BASE_RESET;
    bit                tx_idle_on   = 1'b1;
    bit                rx_idle_on   = 1'b1;
    int                hold_left    = 0;
    int unsigned       cycle_count  = 0;
    int unsigned       values_sent  = 0;
    int unsigned       chars_seen   = 0;
    int unsigned       base_writes  = 0;
    int unsigned       mismatches   = 0;
    int unsigned       unexpected   = 0;

    integer_to_base_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_value         (i_value),
        .i_number_base_we(i_number_base_we),
        .i_number_base   (i_number_base),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_character     (o_character),
        .o_last_char     (o_last_char)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d characters pending.",
                     cycle_count, expected_chars.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver side: a requested hold-off takes priority over random idling.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (rx_idle_on) begin
            i_stall <= ($urandom_range(99) < IDLE_PCT);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_char_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= MAX_REPORT) begin
                    $display("Unexpected character 0x%02h last=%0b at cycle %0d",
                             o_character, o_last_char, cycle_count);
                end
            end else begin
                want = expected_chars.pop_front();
                if (want.character !== o_character || want.last_char !== o_last_char) begin
                    mismatches++;
                    if (mismatches + unexpected <= MAX_REPORT) begin
                        $display({"Mismatch at cycle %0d: expected 0x%02h last=%0b, ",
                                  "got 0x%02h last=%0b"},
                                 cycle_count, want.character, want.last_char,
                                 o_character, o_last_char);
                    end
                end
            end
        end
    end

    function automatic ibase_pkg::t_digit radix_of(input ibase_pkg::t_digit setting);
        if (setting < ibase_pkg::C_RADIX_MIN) begin
            return ibase_pkg::C_RADIX_MIN;
        end
        if (setting > ibase_pkg::C_RADIX_MAX) begin
            return ibase_pkg::C_RADIX_MAX;
        end
        return setting;
    endfunction

    function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] radix;
        ibase_pkg::t_digit     digits[VALUE_BITS];
        ibase_pkg::t_digit     d;
        int                    count;
        t_char_rec             rec;
        radix = VALUE_BITS'(radix_of(base_setting));
        mag   = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
        count = 0;
        do begin
            digits[count] = ibase_pkg::t_digit'(mag % radix);
            count++;
            mag = mag / radix;
        end while (mag != 0);
        if (value[VALUE_BITS-1]) begin
            rec.character = ibase_pkg::C_ASCII_MINUS;
            rec.last_char = 1'b0;
            expected_chars.push_back(rec);
        end
        for (int k = count - 1; k >= 0; k--) begin
            d = digits[k];
            if (d < ibase_pkg::C_DECIMAL_LIMIT) begin
                rec.character = ibase_pkg::C_ASCII_ZERO + ibase_pkg::t_char'(d);
            end else begin
                rec.character = ibase_pkg::C_ASCII_UPPER_A +
                                ibase_pkg::t_char'(d - ibase_pkg::C_DECIMAL_LIMIT);
            end
            rec.last_char = (k == 0);
            expected_chars.push_back(rec);
        end
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [VALUE_BITS-1:0] p;
        logic [VALUE_BITS-1:0] radix;
        int                    power;
        radix = VALUE_BITS'(radix_of(base_setting));
        case ($urandom_range(9))
            0: pick_value = VALUE_BITS'($urandom_range(40));
            1: pick_value = -VALUE_BITS'($urandom_range(40));
            2: begin
                case ($urandom_range(3))
                    0: pick_value = {1'b1, {(VALUE_BITS-1){1'b0}}};
                    1: pick_value = {1'b0, {(VALUE_BITS-1){1'b1}}};
                    2: pick_value = '1;
                    default: pick_value = '0;
                endcase
            end
            3, 4: begin
                p     = 1;
                power = $urandom_range(1, 31);
                repeat (power) p = p * radix;
                p = p + VALUE_BITS'($urandom_range(2)) - 1'b1;
                pick_value = $urandom_range(1) ? -p : p;
            end
            default: pick_value = VALUE_BITS'($urandom);
        endcase
    endfunction

    // Called and returns at a falling edge; valid stays high after the transaction.
    task automatic send_value(input logic [VALUE_BITS-1:0] value);
        predict_text(value);
        if (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        values_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_chars.size() != 0) @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    task automatic write_base(input ibase_pkg::t_digit setting);
        wait_drained();
        i_number_base_we <= 1'b1;
        i_number_base    <= setting;
        @(negedge i_clk);
        i_number_base_we <= 1'b0;
        base_setting = setting;
        base_writes++;
    endtask

    task automatic test_reset_base();
        send_value('0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
    endtask

    task automatic test_base_extremes();
        write_base(6'd2);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        write_base(6'd36);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd35);
        send_value(32'd1295);
        write_base(6'd16);
        send_value(32'hDEAD_BEEF);
        send_value(32'h1234_5678);
        write_base(6'd0);
        send_value(32'd5);
        write_base(6'd1);
        send_value(-32'd6);
        write_base(6'd37);
        send_value(32'd35);
        write_base(6'd63);
        send_value(-32'd36);
    endtask

    task automatic test_random_values();
        ibase_pkg::t_digit phase_bases[6] = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd37, 6'd1};
        for (int phase = 0; phase < 10; phase++) begin
            if (phase < 6) begin
                write_base(phase_bases[phase]);
            end else begin
                write_base(ibase_pkg::t_digit'($urandom_range(63)));
            end
            repeat (30) send_value(pick_value());
        end
    endtask

    task automatic test_output_hold();
        write_base(6'd10);
        hold_left = HOLD_LEN;
        repeat (8) send_value(pick_value());
    endtask

    task automatic test_sender_pause();
        repeat (3) begin
            repeat (4) send_value(pick_value());
            wait_drained();
        end
    endtask

    task automatic test_no_idle();
        write_base(ibase_pkg::t_digit'($urandom_range(2, 36)));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (40) send_value(pick_value());
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_base();
        test_base_extremes();
        test_random_values();
        test_output_hold();
        test_sender_pause();
        test_no_idle();
        wait_drained();
        repeat (END_GAP) @(posedge i_clk);
        $display("Sent %0d values and checked %0d characters across %0d radix settings.",
                 values_sent, chars_seen, base_writes + 1);
        $display("Mismatches: %0d, unexpected characters: %0d, still pending: %0d.",
                 mismatches, unexpected, expected_chars.size());
        if (mismatches == 0 && unexpected == 0 && expected_chars.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/ibase_pkg.sv
hdl/ibase_cell.sv
hdl/ibase_array.sv
hdl/integer_to_base_ascii.sv
verif/integer_to_base_ascii_tb.sv
